[rtl/reb_pkg.sv]
// Shared types, constants and the full-step quadrature table for the
// rotary encoder / push button decoder. No dependencies.
package reb_pkg;

  // Default width of the press tick counter.
  localparam int unsigned PRESS_COUNT_BITS = 24;

  // Long-press threshold register.
  localparam int unsigned        LptW      = 24;
  localparam logic [LptW-1:0]    LptReset  = LptW'(1000);

  // Register map: register index is paddr[2].
  localparam int unsigned        PaddrW    = 3;
  localparam logic               RegLongPress = 1'b0;
  localparam logic               RegInvert    = 1'b1;

  typedef enum logic [1:0] {
    ROT_NONE = 2'd0,
    ROT_UP   = 2'd1,
    ROT_DOWN = 2'd2
  } rot_ev_e;

  typedef enum logic [1:0] {
    BTN_NONE   = 2'd0,
    BTN_SELECT = 2'd1,
    BTN_LONG   = 2'd2
  } btn_ev_e;

  // Direction tag carried by a table entry.
  localparam logic [1:0] DirNone = 2'b00;
  localparam logic [1:0] DirCw   = 2'b01;
  localparam logic [1:0] DirCcw  = 2'b10;

  typedef struct packed {
    logic [23:0] long_press_ticks;
    logic        invert_direction;
  } cfg_t;

  typedef struct packed {
    logic [1:0] dir;
    logic [2:0] phase;
  } step_t;

  // Full-step table: rows are phases 0..6, columns the pin code {dt, clk}.
  // Bounce walks back toward the start state without a direction tag.
  localparam step_t StepTable [7][4] = '{
    '{'{DirNone, 3'd0}, '{DirNone, 3'd2}, '{DirNone, 3'd4}, '{DirNone, 3'd0}},
    '{'{DirNone, 3'd3}, '{DirNone, 3'd0}, '{DirNone, 3'd1}, '{DirCw,   3'd0}},
    '{'{DirNone, 3'd3}, '{DirNone, 3'd2}, '{DirNone, 3'd0}, '{DirNone, 3'd0}},
    '{'{DirNone, 3'd3}, '{DirNone, 3'd2}, '{DirNone, 3'd1}, '{DirNone, 3'd0}},
    '{'{DirNone, 3'd6}, '{DirNone, 3'd0}, '{DirNone, 3'd4}, '{DirNone, 3'd0}},
    '{'{DirNone, 3'd6}, '{DirNone, 3'd5}, '{DirNone, 3'd0}, '{DirCcw,  3'd0}},
    '{'{DirNone, 3'd6}, '{DirNone, 3'd5}, '{DirNone, 3'd4}, '{DirNone, 3'd0}}
  };

  // Phase 7 is unreachable; decode it as the start state.
  function automatic step_t quad_step(logic [2:0] phase, logic [1:0] pins);
    step_t res;
    if (phase == 3'd7) begin
      res = StepTable[0][pins];
    end else begin
      res = StepTable[phase][pins];
    end
    return res;
  endfunction

endpackage

[rtl/reb_if.sv]
// Handshake channels for the encoder decoder: sample tick in, events out.
// Depends on reb_pkg for the event types.
interface reb_in_if;
  logic valid;
  logic ready;
  logic clk_level;
  logic dt_level;
  logic switch_level;

  modport source (output valid, clk_level, dt_level, switch_level, input ready);
  modport sink   (input valid, clk_level, dt_level, switch_level, output ready);
endinterface

interface reb_out_if;
  logic             valid;
  logic             ready;
  reb_pkg::rot_ev_e rotate_event;
  reb_pkg::btn_ev_e button_event;
  logic             button_held;

  modport source (output valid, rotate_event, button_event, button_held, input ready);
  modport sink   (input valid, rotate_event, button_event, button_held, output ready);
endinterface

[rtl/rotary_encoder_button_decoder.sv]
// Top level of the rotary encoder and push button decoder.
// Depends on reb_pkg, reb_in_if/reb_out_if, reb_quad and reb_button.
//
// Channel   | Dir | Payload                                   | Per transfer
// ----------+-----+-------------------------------------------+---------------------
// item_i    | in  | clk_level, dt_level, switch_level         | one sample tick
// result_o  | out | rotate_event, button_event, button_held   | one result per tick
// APB       | in  | paddr 0: long_press_ticks, 4: invert      | register write/read
//
// Cycles: a tick is captured in an input register, stepped through the phase
// table and the button logic, and lands in the result register; one tick is
// taken every cycle while the result side is not stalled.
// Reset: asynchronous, active low; phase at start, switch released, counter
// clear, registers at 1000 ticks and no inversion. No clearing pass.
// Stalls: the result register holds until taken; the input register fills
// behind it, after which item_i.ready drops.
module rotary_encoder_button_decoder #(
  parameter int unsigned PressCountBits = reb_pkg::PRESS_COUNT_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  reb_in_if.sink                     item_i,
  reb_out_if.source                  result_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [reb_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  // ---------------- configuration registers ----------------
  reb_pkg::cfg_t cfg_q;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks <= reb_pkg::LptReset;
      cfg_q.invert_direction <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        reb_pkg::RegLongPress: cfg_q.long_press_ticks <= pwdata[reb_pkg::LptW-1:0];
        reb_pkg::RegInvert:    cfg_q.invert_direction <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      reb_pkg::RegLongPress: prdata = 32'(cfg_q.long_press_ticks);
      reb_pkg::RegInvert:    prdata = 32'(cfg_q.invert_direction);
      default:               prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  logic       in_valid_q;
  logic [1:0] pins_q;
  logic       sw_q;
  logic       out_free;
  logic       advance;

  // Result slot is free when empty or being taken this cycle.
  assign out_free     = !result_o.valid || result_o.ready;
  assign advance      = in_valid_q && out_free;
  assign item_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.ready && item_i.valid) begin
      pins_q <= {item_i.dt_level, item_i.clk_level};
      sw_q   <= item_i.switch_level;
    end
  end

  // ---------------- per-tick logic ----------------
  reb_pkg::rot_ev_e rot_ev;
  reb_pkg::btn_ev_e btn_ev;

  // State in both units moves only when the tick passes into the result slot.
  reb_quad u_quad (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .pins_i   (pins_q),
    .invert_i (cfg_q.invert_direction),
    .event_o  (rot_ev)
  );

  reb_button #(
    .PressCountBits (PressCountBits)
  ) u_button (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .pressed_i   (!sw_q),
    .threshold_i (cfg_q.long_press_ticks),
    .event_o     (btn_ev)
  );

  // ---------------- result register ----------------
  logic             out_valid_q;
  reb_pkg::rot_ev_e rot_q;
  reb_pkg::btn_ev_e btn_q;
  logic             held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rot_q  <= rot_ev;
      btn_q  <= btn_ev;
      held_q <= !sw_q;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.rotate_event = rot_q;
  assign result_o.button_event = btn_q;
  assign result_o.button_held  = held_q;

endmodule

[rtl/reb_quad.sv]
// Quadrature phase tracker: holds the table state and flags completed detents.
// Depends on reb_pkg.
module reb_quad (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [1:0]       pins_i,
  input  logic             invert_i,
  output reb_pkg::rot_ev_e event_o
);

  logic [2:0]     phase_q, phase_d;
  reb_pkg::step_t nxt;

  always_comb begin
    nxt     = reb_pkg::quad_step(phase_q, pins_i);
    phase_d = nxt.phase;
    unique case (nxt.dir)
      reb_pkg::DirCw:  event_o = invert_i ? reb_pkg::ROT_UP : reb_pkg::ROT_DOWN;
      reb_pkg::DirCcw: event_o = invert_i ? reb_pkg::ROT_DOWN : reb_pkg::ROT_UP;
      default:         event_o = reb_pkg::ROT_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 3'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
    end
  end

endmodule

[rtl/reb_button.sv]
// Push switch tracker: press edge, saturating hold counter, long-press flag.
// Depends on reb_pkg.
module reb_button #(
  parameter int unsigned PressCountBits = reb_pkg::PRESS_COUNT_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  logic                     pressed_i,
  input  logic [reb_pkg::LptW-1:0] threshold_i,
  output reb_pkg::btn_ev_e         event_o
);

  localparam int unsigned CmpW =
    (PressCountBits > reb_pkg::LptW) ? PressCountBits : reb_pkg::LptW;

  logic                      prev_q, prev_d;
  logic                      fired_q, fired_d;
  logic [PressCountBits-1:0] cnt_q, cnt_d;

  logic                      new_press;
  logic [PressCountBits-1:0] cnt_base, cnt_inc;
  logic                      fired_base;
  logic [reb_pkg::LptW-1:0]  thr;
  logic                      reached;

  always_comb begin
    new_press  = pressed_i && prev_q;
    cnt_base   = new_press ? '0 : cnt_q;
    fired_base = new_press ? 1'b0 : fired_q;
    cnt_inc    = (cnt_base == '1) ? cnt_base : cnt_base + PressCountBits'(1);
    // A zero threshold acts as one.
    thr        = (threshold_i == '0) ? reb_pkg::LptW'(1) : threshold_i;
    reached    = CmpW'(cnt_inc) >= CmpW'(thr);
    prev_d     = !pressed_i;
    event_o    = reb_pkg::BTN_NONE;
    if (pressed_i) begin
      cnt_d   = cnt_inc;
      fired_d = fired_base;
      if (!fired_base && reached) begin
        fired_d = 1'b1;
        event_o = reb_pkg::BTN_LONG;
      end
    end else begin
      cnt_d   = '0;
      fired_d = fired_q;
      if (!prev_q && !fired_q) begin
        event_o = reb_pkg::BTN_SELECT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b1;
      fired_q <= 1'b0;
      cnt_q   <= '0;
    end else if (step_i) begin
      prev_q  <= prev_d;
      fired_q <= fired_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[tb/tb.sv]
// Self-checking testbench for rotary_encoder_button_decoder: directed ticks, then random
// detent, bounce and press sequences, checked against typed results or a cycle-free model.
// Depends on reb_pkg, reb_in_if / reb_out_if and the decoder RTL.
module tb;

  localparam int CntW       = reb_pkg::PRESS_COUNT_BITS;
  localparam int WatchLimit = 1000;  // cycles with no transfer before giving up
  localparam int RandPhases = 10;
  localparam int PhaseTicks = 115;
  localparam int HoldOff    = 80;    // long result stall, enough to back up item_i

  // Detent map entry: {dir tag[1:0], next phase[2:0]}; rows are phases, columns {dt, clk}.
  localparam logic [1:0] TagCw  = 2'b01;
  localparam logic [1:0] TagCcw = 2'b10;
  localparam logic [4:0] DetentMap [7][4] = '{
    '{5'h00, 5'h02, 5'h04, 5'h00},
    '{5'h03, 5'h00, 5'h01, 5'h08},  // last step of a clockwise detent
    '{5'h03, 5'h02, 5'h00, 5'h00},
    '{5'h03, 5'h02, 5'h01, 5'h00},
    '{5'h06, 5'h00, 5'h04, 5'h00},
    '{5'h06, 5'h05, 5'h00, 5'h10},  // last step of a counter-clockwise detent
    '{5'h06, 5'h05, 5'h04, 5'h00}
  };
  // Pin codes {dt, clk} of one full detent in each direction.
  localparam logic [1:0] CwCodes  [4] = '{2'd1, 2'd0, 2'd2, 2'd3};
  localparam logic [1:0] CcwCodes [4] = '{2'd2, 2'd0, 2'd1, 2'd3};

  typedef struct packed {
    reb_pkg::rot_ev_e rot;
    reb_pkg::btn_ev_e btn;
    logic             held;
  } tick_res_t;

  // Directed row: either a register update (wr) or one sample tick. When chk is set the
  // expected result is typed in; otherwise the tick model supplies it.
  typedef struct packed {
    logic             wr;
    logic [23:0]      lpt;
    logic             inv;
    logic             c;
    logic             d;
    logic             s;
    logic             chk;
    reb_pkg::rot_ev_e rot;
    reb_pkg::btn_ev_e btn;
    logic             held;
  } dir_row_t;

  localparam int NumRows = 29;
  localparam dir_row_t Directed [NumRows] = '{
    // idle pins right after reset
    '{1'b0, 24'd0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, reb_pkg::ROT_NONE, reb_pkg::BTN_NONE, 1'b0},
    // clockwise detent reports down
    '{1'b0, 24'd0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, reb_pkg::ROT_NONE, reb_pkg::BTN_NONE, 1'b0},
    '{1'b0, 24'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, reb_pkg::ROT_NONE, reb_pkg::BTN_NONE, 1'b0},
    '{1'b0, 24'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, reb_pkg::ROT_NONE, reb_pkg::BTN_NONE, 1'b0},
    '{1'b0, 24'd0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, reb_pkg::ROT_DOWN, reb_pkg::BTN_NONE, 1'b0},
    // counter-clockwise detent reports up
    '{1'b0, 24'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, reb_pkg::ROT_NONE, reb_pkg::BTN_NONE, 1'b0},
    '{1'b0, 24'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, reb_pkg::ROT_NONE, reb_pkg::BTN_NONE, 1'b0},
    '{1'b0, 24'd0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, reb_pkg::ROT_NONE, reb_pkg::BTN_NONE, 1'b0},
    '{1'b0, 24'd0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, reb_pkg::ROT_UP,   reb_pkg::BTN_NONE, 1'b0},
    // contact bounce walks back and aborts the detent
    '{1'b0, 24'd0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, reb_pkg::ROT_NONE, reb_pkg::BTN_NONE, 1'b0},
    '{1'b0, 24'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, reb_pkg::ROT_NONE, reb_pkg::BTN_NONE, 1'b0},
    '{1'b0, 24'd0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, reb_pkg::ROT_NONE, reb_pkg::BTN_NONE, 1'b0},
    '{1'b0, 24'd0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, reb_pkg::ROT_NONE, reb_pkg::BTN_NONE, 1'b0},
    // short click under the reset threshold gives select
    '{1'b0, 24'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, reb_pkg::ROT_NONE, reb_pkg::BTN_NONE, 1'b1},
    '{1'b0, 24'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, reb_pkg::ROT_NONE, reb_pkg::BTN_NONE, 1'b1},
    '{1'b0, 24'd0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, reb_pkg::ROT_NONE, reb_pkg::BTN_SELECT, 1'b0},
    // lowest threshold, directions swapped
    '{1'b1, 24'd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, reb_pkg::ROT_NONE, reb_pkg::BTN_NONE, 1'b0},
    '{1'b0, 24'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, reb_pkg::ROT_NONE, reb_pkg::BTN_LONG, 1'b1},
    '{1'b0, 24'd0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, reb_pkg::ROT_NONE, reb_pkg::BTN_NONE, 1'b0},
    // press during a detent; release after long press is silent
    '{1'b0, 24'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, reb_pkg::ROT_NONE, reb_pkg::BTN_NONE, 1'b0},
    '{1'b0, 24'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, reb_pkg::ROT_NONE, reb_pkg::BTN_NONE, 1'b0},
    '{1'b0, 24'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, reb_pkg::ROT_NONE, reb_pkg::BTN_NONE, 1'b0},
    '{1'b0, 24'd0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, reb_pkg::ROT_UP,   reb_pkg::BTN_NONE, 1'b0},
    // zero threshold acts as one: long press on the press tick
    '{1'b1, 24'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, reb_pkg::ROT_NONE, reb_pkg::BTN_NONE, 1'b0},
    '{1'b0, 24'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, reb_pkg::ROT_NONE, reb_pkg::BTN_LONG, 1'b1},
    '{1'b0, 24'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, reb_pkg::ROT_NONE, reb_pkg::BTN_NONE, 1'b0},
    // highest threshold, click gives select
    '{1'b1, 24'hFFFFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      reb_pkg::ROT_NONE, reb_pkg::BTN_NONE, 1'b0},
    '{1'b0, 24'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, reb_pkg::ROT_NONE, reb_pkg::BTN_NONE, 1'b0},
    '{1'b0, 24'd0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, reb_pkg::ROT_NONE, reb_pkg::BTN_SELECT, 1'b0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  reb_in_if  item_if ();
  reb_out_if res_if ();

  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [reb_pkg::PaddrW-1:0] paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;

  rotary_encoder_button_decoder uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (res_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Results still owed by the decoder, oldest first.
  tick_res_t pending_res [$];
  int        errors   = 0;
  bit        calm     = 1'b0;  // no idle cycles on either side while set
  int        hold_len = 0;     // one-shot long stall request for the result side

  // Tick model state and its copy of the registers.
  logic [2:0]      enc_phase;
  logic            sw_prev;
  logic [CntW-1:0] press_cnt;
  logic            long_done;
  logic [23:0]     lp_thresh;
  logic            dir_swap;

  // One sample tick through the detent map and the press tracker.
  function automatic tick_res_t predict_tick(input logic c, input logic d, input logic s);
    logic [2:0]  row;
    logic [4:0]  ent;
    logic [24:0] thr;
    tick_res_t   r;
    row = (enc_phase == 3'd7) ? 3'd0 : enc_phase;  // unused phase code decodes as start
    ent = DetentMap[row][{d, c}];
    enc_phase = ent[2:0];
    r.rot = reb_pkg::ROT_NONE;
    if (ent[4:3] == TagCw) begin
      r.rot = dir_swap ? reb_pkg::ROT_UP : reb_pkg::ROT_DOWN;
    end else if (ent[4:3] == TagCcw) begin
      r.rot = dir_swap ? reb_pkg::ROT_DOWN : reb_pkg::ROT_UP;
    end
    r.btn = reb_pkg::BTN_NONE;
    thr = (lp_thresh == '0) ? 25'd1 : {1'b0, lp_thresh};
    if (!s) begin
      if (sw_prev) begin
        long_done = 1'b0;
        press_cnt = '0;
      end
      if (press_cnt != '1) begin
        press_cnt = press_cnt + 1'b1;  // saturates at all ones
      end
      if (!long_done && press_cnt >= thr) begin
        long_done = 1'b1;
        r.btn     = reb_pkg::BTN_LONG;
      end
    end else begin
      if (!sw_prev && !long_done) begin
        r.btn = reb_pkg::BTN_SELECT;
      end
      press_cnt = '0;
    end
    sw_prev = s;
    r.held  = !s;
    return r;
  endfunction

  // Offer one tick after a random gap; the expectation is queued on the transfer edge.
  task automatic send_tick(input logic c, input logic d, input logic s, input tick_res_t want);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid        <= 1'b1;
    item_if.clk_level    <= c;
    item_if.dt_level     <= d;
    item_if.switch_level <= s;
    do @(posedge clk_i); while (!item_if.ready);
    pending_res.push_back(want);
  endtask

  // Stop offering, drain every owed result, then cover the input and result registers.
  task automatic wait_idle();
    item_if.valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // One APB transfer: setup, access, then a return to psel low.
  task automatic apb_access(input logic wr, input logic [reb_pkg::PaddrW-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write both registers while idle, read them back, update the model's copy.
  task automatic write_cfg(input logic [23:0] lpt, input logic inv);
    logic [reb_pkg::PaddrW-1:0] addr [2];
    logic [31:0]                want [2];
    logic [31:0]                rd;
    addr[0] = {reb_pkg::RegLongPress, 2'b00};
    addr[1] = {reb_pkg::RegInvert, 2'b00};
    want[0] = {8'd0, lpt};
    want[1] = {31'd0, inv};
    wait_idle();
    for (int i = 0; i < 2; i++) begin
      apb_access(1'b1, addr[i], want[i], rd);
    end
    for (int i = 0; i < 2; i++) begin
      apb_access(1'b0, addr[i], 32'd0, rd);
      if (rd !== want[i]) begin
        $error("prdata @%0d: expected %0h, actual %0h", addr[i], want[i], rd);
        errors++;
      end
    end
    lp_thresh = lpt;
    dir_swap  = inv;
  endtask

  // Result side: random or requested stalls, then compare each transfer with the oldest
  // expectation.
  initial begin : result_sink
    int        gap;
    tick_res_t got;
    tick_res_t want;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_len > 0) begin
        res_if.ready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
      end else begin
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
          res_if.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      got.rot  = res_if.rotate_event;
      got.btn  = res_if.button_event;
      got.held = res_if.button_held;
      if (pending_res.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        want = pending_res.pop_front();
        if (got.rot !== want.rot) begin
          $error("rotate_event: expected %0d, actual %0d", want.rot, got.rot);
          errors++;
        end
        if (got.btn !== want.btn) begin
          $error("button_event: expected %0d, actual %0d", want.btn, got.btn);
          errors++;
        end
        if (got.held !== want.held) begin
          $error("button_held: expected %0d, actual %0d", want.held, got.held);
          errors++;
        end
      end
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WatchLimit) begin
        $display("rotary_encoder_button_decoder regression: fail");
        $finish;
      end
    end
  end

  // Stimulus: directed table, then random phases, each under its own register setting.
  initial begin : stimulus
    tick_res_t   r;
    dir_row_t    row;
    logic [1:0]  pin_seq [$];
    logic [1:0]  code;
    logic [1:0]  prev_code;
    logic [23:0] lpt;
    logic        sw_lvl;
    int          sw_run;
    int          press_max;
    int          pick;
    int          reps;

    item_if.valid        <= 1'b0;
    item_if.clk_level    <= 1'b0;
    item_if.dt_level     <= 1'b0;
    item_if.switch_level <= 1'b1;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_ni  <= 1'b0;

    enc_phase = 3'd0;
    sw_prev   = 1'b1;
    press_cnt = '0;
    long_done = 1'b0;
    lp_thresh = reb_pkg::LptReset;
    dir_swap  = 1'b0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part starts from reset register values.
    for (int i = 0; i < NumRows; i++) begin
      row = Directed[i];
      if (row.wr) begin
        write_cfg(row.lpt, row.inv);
      end else begin
        r = predict_tick(row.c, row.d, row.s);
        if (row.chk) begin
          r = '{rot: row.rot, btn: row.btn, held: row.held};
        end
        send_tick(row.c, row.d, row.s, r);
      end
    end

    // Random part: mostly clean detents with repeats and bounce, some pin noise, and
    // press runs sized around the threshold so both select and long press occur.
    sw_lvl = 1'b1;
    sw_run = 0;
    prev_code = 2'd3;
    for (int ph = 0; ph < RandPhases; ph++) begin
      case (ph)
        0:       lpt = 24'd1000;
        1:       lpt = 24'd1;
        2:       lpt = 24'd3;
        3:       lpt = 24'hFFFFFF;
        4:       lpt = 24'd12;
        5:       lpt = 24'd2;
        6:       lpt = 24'd30;
        7:       lpt = 24'd7;
        default: lpt = 24'($urandom_range(1, 40));
      endcase
      write_cfg(lpt, ph[0]);
      press_max = (lpt < 30) ? 2 * int'(lpt) + 3 : 45;
      calm      = (ph == 5) || (ph == 8);
      if (ph == 3) begin
        hold_len = HoldOff;  // result side stalls while ticks keep coming
      end
      for (int n = 0; n < PhaseTicks; n++) begin
        if (pin_seq.size() == 0) begin
          pick = $urandom_range(0, 9);
          if (pick < 8) begin
            for (int k = 0; k < 4; k++) begin
              code = (pick < 4) ? CwCodes[k] : CcwCodes[k];
              reps = $urandom_range(1, 3);
              for (int j = 0; j < reps; j++) pin_seq.push_back(code);
              if (k > 0 && k < 3 && $urandom_range(0, 6) == 0) begin
                pin_seq.push_back(prev_code);  // bounce back one step
                pin_seq.push_back(code);
              end
              prev_code = code;
            end
          end else begin
            reps = $urandom_range(1, 4);
            for (int j = 0; j < reps; j++) pin_seq.push_back(2'($urandom_range(0, 3)));
          end
        end
        code = pin_seq.pop_front();
        if (sw_run == 0) begin
          sw_lvl = ~sw_lvl;
          sw_run = sw_lvl ? $urandom_range(1, 20) : $urandom_range(1, press_max);
        end
        sw_run--;
        r = predict_tick(code[0], code[1], sw_lvl);
        send_tick(code[0], code[1], sw_lvl, r);
      end
    end
    calm = 1'b0;

    wait_idle();
    if (errors == 0) begin
      $display("rotary_encoder_button_decoder regression: pass");
    end else begin
      $display("rotary_encoder_button_decoder regression: fail");
    end
    $finish;
  end

endmodule
